// ===== rtl/pbk_pkg.sv =====
package pbk_pkg;

	// default coordinate format
	localparam int COORD_BITS_DEF    = 32;
	localparam int FRACTION_BITS_DEF = 16;

	// reciprocal of the near-linear threshold
	localparam int                  EPS_INV_W = 37;
	localparam logic [EPS_INV_W-1:0] EPS_INV  = 37'd100000000000;

	// result kind codes
	typedef enum logic [2:0] {
		KIND_QUAD   = 3'd0,
		KIND_ON1    = 3'd1,
		KIND_ON2    = 3'd2,
		KIND_LIN    = 3'd3,
		KIND_NOROOT = 3'd4,
		KIND_SAT    = 3'd5
	} kind_t;

	// control of one pipeline cell
	typedef struct packed {
		logic en;
		logic vld;
	} cell_ctl_t;

endpackage

// ===== rtl/pbk_sqrt_cell.sv =====
module pbk_sqrt_cell #(
	parameter int PW  = 132,
	parameter int RB  = 66,
	parameter int BIT = 0,
	parameter int SW  = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pbk_pkg::cell_ctl_t  ctl_i,
	input  logic [PW-1:0]       rem_i,
	input  logic [RB-1:0]       root_i,
	input  logic [SW-1:0]       side_i,
	output logic                vld_o,
	output logic [PW-1:0]       rem_o,
	output logic [RB-1:0]       root_o,
	output logic [SW-1:0]       side_o
);

	localparam int TW = PW + 2;

	logic [TW-1:0] root_ext;
	logic [TW-1:0] rem_ext;
	logic [TW-1:0] trial;
	logic          take;
	logic [RB-1:0] root_nx;

	// (root + 2^bit)^2 - root^2
	assign root_ext = TW'(root_i);
	assign rem_ext  = TW'(rem_i);
	assign trial    = (root_ext << (BIT + 1)) + (TW'(1) << (2 * BIT));
	assign take     = rem_ext >= trial;

	always_comb begin
		root_nx      = root_i;
		root_nx[BIT] = take;
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (ctl_i.en) begin
			vld_o <= ctl_i.vld;
		end
	end

	// remainder, partial root and sideband
	always_ff @(posedge clk) begin
		if (ctl_i.en) begin
			rem_o  <= take ? PW'(rem_ext - trial) : rem_i;
			root_o <= root_nx;
			side_o <= side_i;
		end
	end

endmodule

// ===== rtl/pbk_div_cell.sv =====
module pbk_div_cell #(
	parameter int NDW = 103,
	parameter int DDW = 68,
	parameter int QB  = 33,
	parameter int BIT = 0,
	parameter int SW  = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  pbk_pkg::cell_ctl_t  ctl_i,
	input  logic [NDW-1:0]      rem_i,
	input  logic [DDW-1:0]      den_i,
	input  logic [QB-1:0]       q_i,
	input  logic [SW-1:0]       side_i,
	output logic                vld_o,
	output logic [NDW-1:0]      rem_o,
	output logic [DDW-1:0]      den_o,
	output logic [QB-1:0]       q_o,
	output logic [SW-1:0]       side_o
);

	logic [NDW-1:0] trial;
	logic           take;
	logic [QB-1:0]  q_nx;

	// one restoring quotient bit
	assign trial = NDW'(den_i) << BIT;
	assign take  = rem_i >= trial;

	always_comb begin
		q_nx      = q_i;
		q_nx[BIT] = take;
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (ctl_i.en) begin
			vld_o <= ctl_i.vld;
		end
	end

	// partial remainder, quotient and sideband
	always_ff @(posedge clk) begin
		if (ctl_i.en) begin
			rem_o  <= take ? (rem_i - trial) : rem_i;
			den_o  <= den_i;
			q_o    <= q_nx;
			side_o <= side_i;
		end
	end

endmodule

// ===== rtl/pbk_out_fifo.sv =====
module pbk_out_fifo #(
	parameter int DW = 35
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [DW-1:0] din,
	output logic          ready,
	output logic          vld,
	input  logic          take,
	output logic [DW-1:0] dout
);

	logic [1:0]    cnt_q;
	logic [DW-1:0] head_q;
	logic [DW-1:0] tail_q;
	logic          pop;

	assign pop   = vld && take;
	assign ready = cnt_q != 2'd2;
	assign vld   = cnt_q != 2'd0;
	assign dout  = head_q;

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	// two entries, head drives the output
	always_ff @(posedge clk) begin
		if (pop && cnt_q == 2'd2) begin
			head_q <= tail_q;
		end else if (push && (cnt_q == 2'd0 || pop)) begin
			head_q <= din;
		end
		if (push && cnt_q == 2'd1 && !pop) begin
			tail_q <= din;
		end
	end

endmodule

// ===== rtl/parabola_breakpoint.sv =====
// Breakpoint of two parabolas of a sweep-line beach front, signed fixed point.
// Each transaction on the slave side carries two foci and the sweep height and
// yields exactly one transaction on the master side: the crossing x and a kind
// code (quadratic root, focus on line, linear, no real root, saturated).
// A new transaction is taken every cycle while s_tready is high. The path runs
// through 2*COORD_BITS + 2 square root cells, COORD_BITS + 1 divider cells, 6
// arithmetic stages and the output queue register; its length is set by the
// two cell chains that produce one root or quotient bit per cell. A two-entry
// output queue lets the slave side keep accepting while a result waits;
// s_tready drops only when both entries are full.
module parabola_breakpoint #(
	parameter int COORD_BITS    = pbk_pkg::COORD_BITS_DEF,
	parameter int FRACTION_BITS = pbk_pkg::FRACTION_BITS_DEF,
	localparam int IN_DW        = ((5 * COORD_BITS + 7) / 8) * 8,
	localparam int OUT_DW       = ((COORD_BITS + 7) / 8) * 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// first_focus_x, first_focus_y, second_focus_x, second_focus_y, sweep_height
	input  logic [IN_DW-1:0]  s_tdata,
	output logic              m_tvalid,
	input  logic              m_tready,
	// cross_x
	output logic [OUT_DW-1:0] m_tdata,
	// result_kind
	output logic [2:0]        m_tuser
);

	localparam int W   = COORD_BITS;
	localparam int EW  = pbk_pkg::EPS_INV_W;
	localparam int CW  = 2 * W + FRACTION_BITS + EW + 4;
	localparam int PW  = 4 * W + 4;
	localparam int RB  = 2 * W + 2;
	localparam int CCW = 3 * W + 4;
	localparam int BW  = 2 * W + 3;
	localparam int NW  = 2 * W + 4;
	localparam int SW5 = 3 * W + 5;
	localparam int ND  = 3 * W + 7;
	localparam int DD  = 2 * W + 4;
	localparam int QB  = W + 1;
	localparam int XW  = W + 3;
	localparam int SQS = W + 5 + (W + 1) + BW + CCW + (2 * W + 2);
	localparam int DVS = W + 6;

	logic advance;

	// input fields
	logic signed [W-1:0] fx1_in, fy1_in, fx2_in, fy2_in, p_in;
	assign fx1_in = s_tdata[W-1:0];
	assign fy1_in = s_tdata[2*W-1:W];
	assign fx2_in = s_tdata[3*W-1:2*W];
	assign fy2_in = s_tdata[4*W-1:3*W];
	assign p_in   = s_tdata[5*W-1:4*W];

	// stage 1: offsets from the sweep line
	logic                v_s1, on1_s1, on2_s1;
	logic signed [W-1:0] fx1_s1, fx2_s1;
	logic signed [W:0]   d1_s1, d2_s1, a_s1, dx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fx1_s1 <= fx1_in;
			fx2_s1 <= fx2_in;
			on1_s1 <= fy1_in == p_in;
			on2_s1 <= fy2_in == p_in;
			d1_s1  <= (W+1)'(fy1_in) - (W+1)'(p_in);
			d2_s1  <= (W+1)'(fy2_in) - (W+1)'(p_in);
			a_s1   <= (W+1)'(fy2_in) - (W+1)'(fy1_in);
			dx_s1  <= (W+1)'(fx2_in) - (W+1)'(fx1_in);
		end
	end

	// stage 2: first products
	logic                  v_s2, on1_s2, on2_s2;
	logic signed [W-1:0]   fx1_s2, fx2_s2;
	logic signed [W:0]     d1_s2, d2_s2, a_s2;
	logic signed [2*W+1:0] pr_s2, dx2_s2, a2_s2, d1dx_s2;
	logic signed [2*W:0]   fx2d1_s2, fx1d2_s2;
	logic signed [2*W-1:0] fx1sq_s2, fx2sq_s2;
	logic [W+EW:0]         lhs_s2;
	logic [W:0]            abs_a;

	assign abs_a = a_s1[W] ? (W+1)'(-a_s1) : (W+1)'(a_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			on1_s2   <= on1_s1;
			on2_s2   <= on2_s1;
			fx1_s2   <= fx1_s1;
			fx2_s2   <= fx2_s1;
			d1_s2    <= d1_s1;
			d2_s2    <= d2_s1;
			a_s2     <= a_s1;
			pr_s2    <= d1_s1 * d2_s1;
			dx2_s2   <= dx_s1 * dx_s1;
			a2_s2    <= a_s1 * a_s1;
			d1dx_s2  <= d1_s1 * dx_s1;
			fx2d1_s2 <= fx2_s1 * d1_s1;
			fx1d2_s2 <= fx1_s1 * d2_s1;
			fx1sq_s2 <= fx1_s1 * fx1_s1;
			fx2sq_s2 <= fx2_s1 * fx2_s1;
			lhs_s2   <= abs_a * pbk_pkg::EPS_INV;
		end
	end

	// stage 3: linear terms, near-linear test and split partial products
	logic                  v_s3, on1_s3, on2_s3, lin_s3, prneg_s3;
	logic signed [W-1:0]   fx1_s3, fx2_s3;
	logic signed [W:0]     a_s3, na;
	logic [2*W+1:0]        sum_s3, abs_pr_s3, abs_pr;
	logic signed [2*W+1:0] d1dx_s3;
	logic signed [BW-1:0]  b_s3;
	logic signed [2*W+1:0] t1lo_s3, t1hi_s3, t2lo_s3, t2hi_s3, t3lo_s3;
	logic signed [2*W+2:0] t3hi_s3;

	assign na     = -a_s2;
	assign abs_pr = pr_s2[2*W+1] ? (2*W+2)'(-pr_s2) : (2*W+2)'(pr_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			on1_s3    <= on1_s2;
			on2_s3    <= on2_s2;
			fx1_s3    <= fx1_s2;
			fx2_s3    <= fx2_s2;
			a_s3      <= a_s2;
			d1dx_s3   <= d1dx_s2;
			prneg_s3  <= pr_s2[2*W+1];
			abs_pr_s3 <= abs_pr;
			sum_s3    <= $unsigned(dx2_s2) + $unsigned(a2_s2);
			b_s3      <= (BW'(fx2d1_s2) - BW'(fx1d2_s2)) <<< 1;
			t1lo_s3   <= $signed({1'b0, fx1sq_s2[W-1:0]}) * d2_s2;
			t1hi_s3   <= $signed({1'b0, fx1sq_s2[2*W-1:W]}) * d2_s2;
			t2lo_s3   <= $signed({1'b0, fx2sq_s2[W-1:0]}) * d1_s2;
			t2hi_s3   <= $signed({1'b0, fx2sq_s2[2*W-1:W]}) * d1_s2;
			t3lo_s3   <= na * $signed({1'b0, pr_s2[W-1:0]});
			t3hi_s3   <= na * $signed(pr_s2[2*W+1:W]);
			lin_s3    <= (CW'(lhs_s2) << FRACTION_BITS) < (CW'(abs_pr) << 1);
		end
	end

	// stage 4: constant term, discriminant partial products and early outcomes
	logic                   v_s4, lin_s4, fixed_s4;
	logic [2:0]             kind_s4;
	logic signed [W-1:0]    xfix_s4;
	logic signed [W:0]      a_s4;
	logic signed [BW-1:0]   b_s4;
	logic signed [CCW-1:0]  c_s4;
	logic signed [2*W+1:0]  d1dx_s4;
	logic [2*W+1:0]         pll_s4, plh_s4, phl_s4, phh_s4;
	logic                   fixed_c;
	pbk_pkg::kind_t         kind_c;
	logic signed [W-1:0]    xfix_c;

	always_comb begin
		fixed_c = 1'b1;
		kind_c  = pbk_pkg::KIND_NOROOT;
		xfix_c  = '0;
		priority if (on1_s3) begin
			kind_c = pbk_pkg::KIND_ON1;
			xfix_c = fx1_s3;
		end else if (on2_s3) begin
			kind_c = pbk_pkg::KIND_ON2;
			xfix_c = fx2_s3;
		end else if (lin_s3 && b_s3 == '0) begin
			kind_c = pbk_pkg::KIND_NOROOT;
		end else if (!lin_s3 && prneg_s3) begin
			kind_c = pbk_pkg::KIND_NOROOT;
		end else begin
			fixed_c = 1'b0;
			kind_c  = pbk_pkg::KIND_QUAD;
			xfix_c  = fx1_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lin_s4   <= lin_s3;
			fixed_s4 <= fixed_c;
			kind_s4  <= kind_c;
			xfix_s4  <= xfix_c;
			a_s4     <= a_s3;
			b_s4     <= b_s3;
			d1dx_s4  <= d1dx_s3;
			pll_s4   <= abs_pr_s3[W:0] * sum_s3[W:0];
			plh_s4   <= abs_pr_s3[W:0] * sum_s3[2*W+1:W+1];
			phl_s4   <= abs_pr_s3[2*W+1:W+1] * sum_s3[W:0];
			phh_s4   <= abs_pr_s3[2*W+1:W+1] * sum_s3[2*W+1:W+1];
			c_s4     <= ((CCW'(t1hi_s3) - CCW'(t2hi_s3) + CCW'(t3hi_s3)) <<< W)
				+ CCW'(t1lo_s3) - CCW'(t2lo_s3) + CCW'(t3lo_s3);
		end
	end

	// stage 5: assemble the discriminant product
	logic           v_s5;
	logic [PW-1:0]  p_s5;
	logic [SQS-1:0] side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (advance) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			p_s5    <= (PW'(phh_s4) << (2 * W + 2))
				+ ((PW'(plh_s4) + PW'(phl_s4)) << (W + 1)) + PW'(pll_s4);
			side_s5 <= {xfix_s4, kind_s4, fixed_s4, lin_s4, a_s4, b_s4, c_s4, d1dx_s4};
		end
	end

	// square root chain, one root bit per cell
	logic [PW-1:0]  sq_rem  [0:RB];
	logic [RB-1:0]  sq_root [0:RB];
	logic [SQS-1:0] sq_side [0:RB];
	logic           sq_vld  [0:RB];

	assign sq_rem[0]  = p_s5;
	assign sq_root[0] = '0;
	assign sq_vld[0]  = v_s5;
	assign sq_side[0] = side_s5;

	for (genvar i = 0; i < RB; i++) begin : g_sqrt
		pbk_sqrt_cell #(
			.PW  (PW),
			.RB  (RB),
			.BIT (RB - 1 - i),
			.SW  (SQS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  ('{en: advance, vld: sq_vld[i]}),
			.rem_i  (sq_rem[i]),
			.root_i (sq_root[i]),
			.side_i (sq_side[i]),
			.vld_o  (sq_vld[i+1]),
			.rem_o  (sq_rem[i+1]),
			.root_o (sq_root[i+1]),
			.side_o (sq_side[i+1])
		);
	end

	// stage 6: pick dividend and divisor
	logic signed [W-1:0]   xfix_r;
	logic [2:0]            kind_r;
	logic                  fixed_r, lin_r;
	logic signed [W:0]     a_r;
	logic signed [BW-1:0]  b_r;
	logic signed [CCW-1:0] c_r;
	logic signed [2*W+1:0] d1dx_r;
	logic signed [NW-1:0]  n_quad;
	logic signed [SW5-1:0] n_sel;
	logic signed [BW-1:0]  d_sel;
	logic [SW5-1:0]        abs_n;
	logic [BW-1:0]         abs_d;

	assign {xfix_r, kind_r, fixed_r, lin_r, a_r, b_r, c_r, d1dx_r} = sq_side[RB];
	assign n_quad = NW'(d1dx_r) + NW'($signed({1'b0, sq_root[RB]}));
	assign n_sel  = lin_r ? -SW5'(c_r) : SW5'(n_quad);
	assign d_sel  = lin_r ? b_r : BW'(a_r);
	assign abs_n  = n_sel[SW5-1] ? SW5'(-n_sel) : SW5'(n_sel);
	assign abs_d  = d_sel[BW-1] ? BW'(-d_sel) : BW'(d_sel);

	logic           v_s6;
	logic [ND-1:0]  num_s6;
	logic [DD-1:0]  den_s6;
	logic [DVS-1:0] side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (advance) begin
			v_s6 <= sq_vld[RB];
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			num_s6  <= (ND'(abs_n) << 1) + ND'(abs_d);
			den_s6  <= {abs_d, 1'b0};
			side_s6 <= {xfix_r, kind_r, fixed_r, lin_r, n_sel[SW5-1] ^ d_sel[BW-1]};
		end
	end

	// divider chain, one quotient bit per cell
	logic [ND-1:0]  dv_rem  [0:QB];
	logic [DD-1:0]  dv_den  [0:QB];
	logic [QB-1:0]  dv_q    [0:QB];
	logic [DVS-1:0] dv_side [0:QB];
	logic           dv_vld  [0:QB];

	assign dv_rem[0]  = num_s6;
	assign dv_den[0]  = den_s6;
	assign dv_q[0]    = '0;
	assign dv_side[0] = side_s6;
	assign dv_vld[0]  = v_s6;

	for (genvar i = 0; i < QB; i++) begin : g_div
		pbk_div_cell #(
			.NDW (ND),
			.DDW (DD),
			.QB  (QB),
			.BIT (QB - 1 - i),
			.SW  (DVS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl_i  ('{en: advance, vld: dv_vld[i]}),
			.rem_i  (dv_rem[i]),
			.den_i  (dv_den[i]),
			.q_i    (dv_q[i]),
			.side_i (dv_side[i]),
			.vld_o  (dv_vld[i+1]),
			.rem_o  (dv_rem[i+1]),
			.den_o  (dv_den[i+1]),
			.q_o    (dv_q[i+1]),
			.side_o (dv_side[i+1])
		);
	end

	// final value, saturation and kind
	logic signed [W-1:0] xfix_f;
	logic [2:0]          kind_f;
	logic                fixed_f, lin_f, qneg_f, ovf, sat, sat_neg;
	logic signed [XW-1:0] qs, xv, xmax, xmin;
	logic [W-1:0]        cross_c;
	logic [2:0]          kind_out;

	assign {xfix_f, kind_f, fixed_f, lin_f, qneg_f} = dv_side[QB];
	// remainder still at least the divisor means the quotient ran out of bits
	assign ovf  = dv_rem[QB] >= ND'(dv_den[QB]);
	assign qs   = qneg_f ? -$signed(XW'(dv_q[QB])) : $signed(XW'(dv_q[QB]));
	assign xv   = lin_f ? qs : XW'(xfix_f) - qs;
	assign xmax = {3'b000, 1'b0, {(W-1){1'b1}}};
	assign xmin = {3'b111, 1'b1, {(W-1){1'b0}}};
	assign sat  = ovf || xv > xmax || xv < xmin;
	assign sat_neg = ovf ? (lin_f ? qneg_f : !qneg_f) : xv[XW-1];

	always_comb begin
		priority if (fixed_f) begin
			cross_c  = xfix_f;
			kind_out = kind_f;
		end else if (sat) begin
			cross_c  = sat_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
			kind_out = pbk_pkg::KIND_SAT;
		end else begin
			cross_c  = xv[W-1:0];
			kind_out = lin_f ? pbk_pkg::KIND_LIN : pbk_pkg::KIND_QUAD;
		end
	end

	// output queue
	logic [W+2:0] fifo_out;

	pbk_out_fifo #(
		.DW (W + 3)
	) u_out_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (advance && dv_vld[QB]),
		.din    ({kind_out, cross_c}),
		.ready  (advance),
		.vld    (m_tvalid),
		.take   (m_tready),
		.dout   (fifo_out)
	);

	assign s_tready = advance;
	assign m_tdata  = OUT_DW'(fifo_out[W-1:0]);
	assign m_tuser  = fifo_out[W+2:W];

	// checks
	a_noroot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == pbk_pkg::KIND_NOROOT |-> m_tdata[W-1:0] == '0)
		else $error("no-root result with nonzero x");

	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == pbk_pkg::KIND_SAT |->
		m_tdata[W-1:0] == {1'b1, {(W-1){1'b0}}} || m_tdata[W-1:0] == {1'b0, {(W-1){1'b1}}})
		else $error("saturated result not at a bound");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with empty output queue");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!advance && dv_vld[QB] |=> dv_vld[QB] && $stable(dv_q[QB]))
		else $error("divider output moved during stall");

endmodule
